[sv/asc_pkg.sv]
package asc_pkg;

  typedef logic [63:0] word_t;
  typedef logic [4:0][63:0] state_t;

  localparam word_t IV_ASCON128 = 64'h8040_0c06_0000_0000;
  localparam word_t PAD_BYTE0   = 64'h8000_0000_0000_0000;

  localparam int unsigned ROUNDS_FULL  = 12;
  localparam int unsigned ROUNDS_BLOCK = 6;
  localparam int unsigned RND_W        = 4;

  // item actions
  localparam logic [1:0] A_START = 2'd0;
  localparam logic [1:0] A_AD    = 2'd1;
  localparam logic [1:0] A_TEXT  = 2'd2;
  localparam logic [1:0] A_FIN   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_SEQ      = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [1:0] CFG_DECRYPT  = 2'd2;

  localparam logic [4:0] TAG_BYTES = 5'd16;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_START     = 6'b000010,
    PH_AD_OPEN   = 6'b000100,
    PH_AD_DONE   = 6'b001000,
    PH_TEXT      = 6'b010000,
    PH_TEXT_DONE = 6'b100000
  } phase_t;

  function automatic logic [7:0] round_const(input logic [RND_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'hf0;
      4'd1:    c = 8'he1;
      4'd2:    c = 8'hd2;
      4'd3:    c = 8'hc3;
      4'd4:    c = 8'hb4;
      4'd5:    c = 8'ha5;
      4'd6:    c = 8'h96;
      4'd7:    c = 8'h87;
      4'd8:    c = 8'h78;
      4'd9:    c = 8'h69;
      4'd10:   c = 8'h5a;
      4'd11:   c = 8'h4b;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic word_t ror64(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // first n bytes of a word, n in 0..7
  function automatic word_t lead_mask(input logic [2:0] n);
    return ~(64'hffff_ffff_ffff_ffff >> {n, 3'b000});
  endfunction

  function automatic word_t pad_bit(input logic [2:0] n);
    return PAD_BYTE0 >> {n, 3'b000};
  endfunction

endpackage

[sv/asc_if.sv]
interface asc_req_if import asc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  word_t      data_high;
  word_t      data_low;
  logic [3:0] byte_count;

  modport source (output valid, action, data_high, data_low, byte_count, input ready);
  modport sink   (input valid, action, data_high, data_low, byte_count, output ready);
endinterface

interface asc_rsp_if import asc_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      result_high;
  word_t      result_low;
  logic [4:0] result_bytes;
  logic [1:0] status;

  modport source (output valid, result_high, result_low, result_bytes, status, input ready);
  modport sink   (input valid, result_high, result_low, result_bytes, status, output ready);
endinterface

interface asc_cfg_if import asc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  word_t      wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

[sv/asc_round.sv]
module asc_round import asc_pkg::*; (
  input  state_t     s_in,
  input  logic [7:0] rc,
  output state_t     s_out
);

  word_t a, b, c, d, e;
  word_t t0, t1, t2, t3, t4;
  word_t u0, u1, u2, u3;

  always_comb begin
    a = s_in[0] ^ s_in[4];
    b = s_in[1];
    c = s_in[2] ^ {56'd0, rc} ^ s_in[1];
    d = s_in[3];
    e = s_in[4] ^ s_in[3];
    // chi-like sbox layer
    t0 = a ^ (~b & c);
    t1 = b ^ (~c & d);
    t2 = c ^ (~d & e);
    t3 = d ^ (~e & a);
    t4 = e ^ (~a & b);
    u1 = t1 ^ t0;
    u0 = t0 ^ t4;
    u3 = t3 ^ t2;
    u2 = ~t2;
    // linear diffusion
    s_out[0] = u0 ^ ror64(u0, 19) ^ ror64(u0, 28);
    s_out[1] = u1 ^ ror64(u1, 61) ^ ror64(u1, 39);
    s_out[2] = u2 ^ ror64(u2, 1)  ^ ror64(u2, 6);
    s_out[3] = u3 ^ ror64(u3, 10) ^ ror64(u3, 17);
    s_out[4] = t4 ^ ror64(t4, 7)  ^ ror64(t4, 41);
  end

endmodule

[sv/ascon128_aead_engine.sv]
// Ascon-128 AEAD engine, one 64-bit block per item, one permutation round per clock on a
// single shared round unit. No new item is taken until the last is through: start and
// finalize run the full permutation, AD and full text blocks the short one, partial text
// blocks and out-of-sequence items none; finalize then passes S_TAG, and an item with a
// result waits in S_EMIT for a free output register. Configuration (key, mode) is written
// through the always-ready config port while the engine is idle; the engine itself does
// not enforce this. Out-of-sequence items leave the state untouched and return status 2.
// On a tag mismatch the plaintext already released must be discarded by the host.
module ascon128_aead_engine import asc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  asc_cfg_if.sink   cfg,
  asc_req_if.sink   req,
  asc_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PERM = 4'b0010,
    S_TAG  = 4'b0100,
    S_EMIT = 4'b1000
  } fsm_t;

  fsm_t             fsm, fsm_acc;
  phase_t           phase, ph_acc;
  state_t           st, st_acc, st_rnd, st_post;
  word_t            key_high, key_low;
  logic             decrypt_mode;
  logic [RND_W-1:0] rnd, rnd_acc;
  logic             post_key, post_acc;
  logic             is_fin, fin_acc;
  logic             has_res, res_acc;
  word_t            tag_high, tag_low;

  word_t            p_high, p_high_acc;
  logic [4:0]       p_bytes, p_bytes_acc;
  logic [1:0]       p_status, p_status_acc;

  logic             out_valid;
  word_t            out_high, out_low;
  logic [4:0]       out_bytes;
  logic [1:0]       out_status;

  logic             full_blk;
  logic [2:0]       n3;
  logic [3:0]       n_eff;
  word_t            m, pad, din, s0, txt;
  logic             accept, out_free;

  assign cfg.ready = 1'b1;
  assign req.ready = (fsm == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.result_high  = out_high;
  assign rsp.result_low   = out_low;
  assign rsp.result_bytes = out_bytes;
  assign rsp.status       = out_status;

  asc_round u_round (
    .s_in  (st),
    .rc    (round_const(rnd)),
    .s_out (st_rnd)
  );

  always_comb begin
    st_post = st_rnd;
    if (post_key) begin
      st_post[3] = st_rnd[3] ^ key_high;
      st_post[4] = st_rnd[4] ^ key_low;
    end
  end

  // item decode and pre-permutation absorb
  always_comb begin
    full_blk     = req.byte_count[3];
    n3           = req.byte_count[2:0];
    n_eff        = full_blk ? 4'd8 : {1'b0, n3};
    m            = lead_mask(n3);
    pad          = pad_bit(n3);
    din          = req.data_high;
    s0           = st[0];
    txt          = '0;
    st_acc       = st;
    ph_acc       = phase;
    fsm_acc      = S_EMIT;
    rnd_acc      = RND_W'(ROUNDS_FULL - ROUNDS_BLOCK);
    post_acc     = 1'b0;
    fin_acc      = 1'b0;
    res_acc      = 1'b0;
    p_high_acc   = '0;
    p_bytes_acc  = '0;
    p_status_acc = ST_SEQ;
    case (req.action)
      A_START: begin
        st_acc[0] = IV_ASCON128;
        st_acc[1] = key_high;
        st_acc[2] = key_low;
        st_acc[3] = req.data_high;
        st_acc[4] = req.data_low;
        rnd_acc   = '0;
        post_acc  = 1'b1;
        ph_acc    = PH_START;
        fsm_acc   = S_PERM;
      end
      A_AD: begin
        if (phase == PH_START || phase == PH_AD_OPEN) begin
          if (full_blk) begin
            st_acc[0] = s0 ^ din;
            ph_acc    = PH_AD_OPEN;
          end else begin
            st_acc[0] = s0 ^ (din & m) ^ pad;
            ph_acc    = PH_AD_DONE;
          end
          fsm_acc = S_PERM;
        end
      end
      A_TEXT: begin
        if (phase == PH_START || phase == PH_AD_DONE || phase == PH_TEXT) begin
          if (phase != PH_TEXT) begin
            st_acc[4] = st[4] ^ 64'd1;
          end
          if (full_blk) begin
            if (decrypt_mode) begin
              txt       = s0 ^ din;
              st_acc[0] = din;
            end else begin
              txt       = s0 ^ din;
              st_acc[0] = s0 ^ din;
            end
            ph_acc  = PH_TEXT;
            fsm_acc = S_PERM;
            res_acc = 1'b1;
          end else begin
            if (decrypt_mode) begin
              txt       = (s0 ^ din) & m;
              st_acc[0] = ((s0 & ~m) | (din & m)) ^ pad;
            end else begin
              txt       = (s0 ^ (din & m)) & m;
              st_acc[0] = s0 ^ (din & m) ^ pad;
            end
            ph_acc = PH_TEXT_DONE;
          end
          p_high_acc   = txt;
          p_bytes_acc  = {1'b0, n_eff};
          p_status_acc = ST_OK;
        end
      end
      A_FIN: begin
        if (phase == PH_START || phase == PH_AD_DONE || phase == PH_TEXT ||
            phase == PH_TEXT_DONE) begin
          // empty final text block when the text was never closed
          if (phase != PH_TEXT_DONE) begin
            st_acc[0] = st[0] ^ PAD_BYTE0;
            if (phase != PH_TEXT) begin
              st_acc[4] = st[4] ^ 64'd1;
            end
          end
          st_acc[1] = st[1] ^ key_high;
          st_acc[2] = st[2] ^ key_low;
          rnd_acc   = '0;
          post_acc  = 1'b1;
          fin_acc   = 1'b1;
          ph_acc    = PH_IDLE;
          fsm_acc   = S_PERM;
        end
      end
      default: begin
        fsm_acc = S_EMIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high     <= '0;
      key_low      <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_KEY_HIGH: key_high     <= cfg.wdata;
        CFG_KEY_LOW:  key_low      <= cfg.wdata;
        CFG_DECRYPT:  decrypt_mode <= cfg.wdata[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      phase     <= PH_IDLE;
      st        <= '0;
      out_valid <= 1'b0;
      rnd       <= '0;
      post_key  <= 1'b0;
      is_fin    <= 1'b0;
      has_res   <= 1'b0;
    end else begin
      // a new result loaded in S_EMIT takes the register over
      if (out_valid && rsp.ready && fsm != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (accept) begin
            fsm      <= fsm_acc;
            st       <= st_acc;
            phase    <= ph_acc;
            rnd      <= rnd_acc;
            post_key <= post_acc;
            is_fin   <= fin_acc;
            has_res  <= res_acc;
            p_high   <= p_high_acc;
            p_bytes  <= p_bytes_acc;
            p_status <= p_status_acc;
            tag_high <= req.data_high;
            tag_low  <= req.data_low;
          end
        end
        S_PERM: begin
          rnd <= rnd + 1'b1;
          if (rnd == RND_W'(ROUNDS_FULL - 1)) begin
            st <= st_post;
            if (is_fin) begin
              fsm <= S_TAG;
            end else if (has_res) begin
              fsm <= S_EMIT;
            end else begin
              fsm <= S_IDLE;
            end
          end else begin
            st <= st_rnd;
          end
        end
        S_TAG: begin
          if (decrypt_mode) begin
            p_high   <= '0;
            p_bytes  <= '0;
            p_status <= (st[3] != tag_high || st[4] != tag_low) ? ST_MISMATCH : ST_OK;
          end else begin
            p_high   <= st[3];
            p_bytes  <= TAG_BYTES;
            p_status <= ST_OK;
          end
          fsm <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_high   <= p_high;
            out_low    <= (is_fin && !decrypt_mode) ? st[4] : '0;
            out_bytes  <= p_bytes;
            out_status <= p_status;
            fsm        <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

endmodule
